>>> hw/rtl/mac_address_text_parser_macros.svh
// Assertion macros for the hardware address text parser
`ifndef MAC_ADDRESS_TEXT_PARSER_MACROS_SVH
`define MAC_ADDRESS_TEXT_PARSER_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every rising clock edge outside reset
`define MAP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// condition must never be true outside reset
`define MAP_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);
`else
`define MAP_ASSERT(label, clk, rstn, prop, msg)
`define MAP_NEVER(label, clk, rstn, cond, msg)
`endif

`endif

>>> hw/rtl/mac_parse_pkg.sv
// Types, constants and character decode for the hardware address text parser
package mac_parse_pkg;

    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned ADDR_W    = 48;
    localparam int unsigned NIBBLE_W  = 4;
    localparam int unsigned LEN_W     = 4;
    localparam int unsigned GCOUNT_W  = 3;
    localparam int unsigned GDIGIT_W  = 2;

    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;

    localparam logic [NIBBLE_W-1:0] ADDR_NIBBLES = 4'd12;
    localparam logic [LEN_W-1:0]    LEN_PLAIN    = 4'd12;
    localparam logic [LEN_W-1:0]    LEN_DASHED   = 4'd13;
    localparam logic [LEN_W-1:0]    DASH_POS     = 4'd6;
    localparam logic [LEN_W-1:0]    LEN_SAT      = 4'd14;
    localparam logic [GCOUNT_W-1:0] GCOUNT_SAT   = 3'd7;
    localparam logic [GDIGIT_W-1:0] GDIGIT_SAT   = 2'd3;
    localparam logic [GDIGIT_W-1:0] GDIGIT_MAX   = 2'd2;
    localparam logic [GCOUNT_W:0]   GROUPS_REQ   = 4'd6;

    typedef enum logic [1:0] {
        SEP_NONE  = 2'd0,
        SEP_COLON = 2'd1,
        SEP_DASH  = 2'd2
    } sep_kind_t;

    typedef struct packed {
        logic                ok;
        logic [NIBBLE_W-1:0] value;
    } hex_digit_t;

    typedef struct packed {
        logic              valid_res;
        logic [ADDR_W-1:0] mac_addr;
    } result_t;

    function automatic hex_digit_t hex_decode(input logic [CHAR_W-1:0] c);
        hex_digit_t d;
        d.ok    = 1'b1;
        d.value = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d.value = NIBBLE_W'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d.value = NIBBLE_W'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d.value = NIBBLE_W'(c - 8'h37);
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

>>> hw/rtl/mac_address_text_parser.sv
// Hardware address text parser: characters in, validity flag and 48-bit address out
//
//  channel | dir | tdata            | tuser     | tlast
//  s_      | in  | [7:0] ch         | -         | terminator
//  m_      | out | [47:0] mac_addr  | valid_res | -
//
//  One character per cycle while s_tready is high; a terminator's result goes to the output register or skid entry.
//  Character state updates in the cycle of the transfer, so strings run back to back.
//  Result path: output register plus one skid entry; s_tready drops only when both are full.
//  aresetn (synchronous) clears parse state and the valid flags of both result slots.
`include "mac_address_text_parser_macros.svh"

module mac_address_text_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [47:0] mac_addr
    output logic        m_tuser    // [0] valid_res
);

    logic [mac_parse_pkg::NIBBLE_W-1:0] nibble_count_reg, nibble_count_next;
    logic                               char_fail_reg, char_fail_next;
    logic [mac_parse_pkg::ADDR_W-1:0]   addr_shift_reg, addr_shift_next;
    logic [mac_parse_pkg::LEN_W-1:0]    length_count_reg, length_count_next;
    logic                               dash_at_six_reg, dash_at_six_next;
    mac_parse_pkg::sep_kind_t           sep_kind_reg, sep_kind_next;
    logic [mac_parse_pkg::GCOUNT_W-1:0] group_count_reg, group_count_next;
    logic [mac_parse_pkg::GDIGIT_W-1:0] group_digits_reg, group_digits_next;
    logic                               group_fail_reg, group_fail_next;

    logic                  out_valid_reg, out_valid_next;
    mac_parse_pkg::result_t out_reg, out_next;
    logic                  skid_valid_reg, skid_valid_next;
    mac_parse_pkg::result_t skid_reg, skid_next;

    logic                         in_xfer;
    logic                         push;
    logic                         pop;
    logic                         is_sep;
    mac_parse_pkg::sep_kind_t     kind;
    mac_parse_pkg::hex_digit_t    digit;
    logic [mac_parse_pkg::GCOUNT_W:0] groups;
    logic                         accept_ok;
    mac_parse_pkg::result_t       result;

    assign s_tready = !skid_valid_reg;
    assign in_xfer  = s_tvalid && s_tready;
    assign push     = in_xfer && s_tlast;
    assign pop      = out_valid_reg && m_tready;

    assign is_sep = (s_tdata == mac_parse_pkg::CHAR_COLON) ||
                    (s_tdata == mac_parse_pkg::CHAR_DASH);
    assign kind   = (s_tdata == mac_parse_pkg::CHAR_COLON) ? mac_parse_pkg::SEP_COLON
                                                           : mac_parse_pkg::SEP_DASH;
    assign digit  = mac_parse_pkg::hex_decode(s_tdata);

    assign groups = {1'b0, group_count_reg} +
                    {{mac_parse_pkg::GCOUNT_W{1'b0}}, (group_digits_reg != '0)};
    assign accept_ok = !char_fail_reg &&
                       (nibble_count_reg == mac_parse_pkg::ADDR_NIBBLES) &&
                       ((length_count_reg == mac_parse_pkg::LEN_PLAIN) ||
                        ((length_count_reg == mac_parse_pkg::LEN_DASHED) && dash_at_six_reg) ||
                        (!group_fail_reg && (groups == mac_parse_pkg::GROUPS_REQ)));

    always_comb begin
        result.valid_res = accept_ok;
        result.mac_addr  = accept_ok ? addr_shift_reg : '0;
    end

    // parse state
    always_comb begin
        nibble_count_next = nibble_count_reg;
        char_fail_next    = char_fail_reg;
        addr_shift_next   = addr_shift_reg;
        length_count_next = length_count_reg;
        dash_at_six_next  = dash_at_six_reg;
        sep_kind_next     = sep_kind_reg;
        group_count_next  = group_count_reg;
        group_digits_next = group_digits_reg;
        group_fail_next   = group_fail_reg;
        if (in_xfer) begin
            if (s_tlast) begin
                nibble_count_next = '0;
                char_fail_next    = 1'b0;
                addr_shift_next   = '0;
                length_count_next = '0;
                dash_at_six_next  = 1'b0;
                sep_kind_next     = mac_parse_pkg::SEP_NONE;
                group_count_next  = '0;
                group_digits_next = '0;
                group_fail_next   = 1'b0;
            end else begin
                if (is_sep) begin
                    if (length_count_reg == mac_parse_pkg::DASH_POS &&
                        kind == mac_parse_pkg::SEP_DASH) begin
                        dash_at_six_next = 1'b1;
                    end
                    if (sep_kind_reg == mac_parse_pkg::SEP_NONE) begin
                        sep_kind_next = kind;
                    end else if (sep_kind_reg != kind) begin
                        group_fail_next = 1'b1;
                    end
                    if (group_digits_reg == '0) begin
                        group_fail_next = 1'b1;
                    end
                    if (group_count_reg != mac_parse_pkg::GCOUNT_SAT) begin
                        group_count_next = group_count_reg + 1'b1;
                    end
                    group_digits_next = '0;
                end else if (digit.ok) begin
                    if (nibble_count_reg >= mac_parse_pkg::ADDR_NIBBLES) begin
                        char_fail_next = 1'b1;
                    end else begin
                        addr_shift_next   = {addr_shift_reg[mac_parse_pkg::ADDR_W-5:0],
                                             digit.value};
                        nibble_count_next = nibble_count_reg + 1'b1;
                    end
                    if (group_digits_reg != mac_parse_pkg::GDIGIT_SAT) begin
                        group_digits_next = group_digits_reg + 1'b1;
                    end
                    if (group_digits_next > mac_parse_pkg::GDIGIT_MAX) begin
                        group_fail_next = 1'b1;
                    end
                end else begin
                    char_fail_next  = 1'b1;
                    group_fail_next = 1'b1;
                end
                if (length_count_reg != mac_parse_pkg::LEN_SAT) begin
                    length_count_next = length_count_reg + 1'b1;
                end
            end
        end
    end

    // result register and skid entry
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = push;
                out_next       = result;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_next       = result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nibble_count_reg <= '0;
            char_fail_reg    <= 1'b0;
            addr_shift_reg   <= '0;
            length_count_reg <= '0;
            dash_at_six_reg  <= 1'b0;
            sep_kind_reg     <= mac_parse_pkg::SEP_NONE;
            group_count_reg  <= '0;
            group_digits_reg <= '0;
            group_fail_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end else begin
            nibble_count_reg <= nibble_count_next;
            char_fail_reg    <= char_fail_next;
            addr_shift_reg   <= addr_shift_next;
            length_count_reg <= length_count_next;
            dash_at_six_reg  <= dash_at_six_next;
            sep_kind_reg     <= sep_kind_next;
            group_count_reg  <= group_count_next;
            group_digits_reg <= group_digits_next;
            group_fail_reg   <= group_fail_next;
            out_valid_reg    <= out_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.mac_addr;
    assign m_tuser  = out_reg.valid_res;

    `MAP_NEVER(a_skid_without_out, aclk, aresetn, skid_valid_reg && !out_valid_reg, "skid entry held while output register empty")
    `MAP_ASSERT(a_invalid_zero_addr, aclk, aresetn, (m_tvalid && !m_tuser) |-> (m_tdata == '0), "rejected string carries a non-zero address")
    `MAP_NEVER(a_nibble_bound, aclk, aresetn, nibble_count_reg > mac_parse_pkg::ADDR_NIBBLES, "nibble count beyond twelve")
    `MAP_ASSERT(a_term_clears, aclk, aresetn, push |=> (nibble_count_reg == '0 && length_count_reg == '0 && group_count_reg == '0), "parse state not cleared after terminator")
    `MAP_ASSERT(a_skid_fill, aclk, aresetn, (push && out_valid_reg && !m_tready) |=> skid_valid_reg, "result lost while output stalled")

endmodule
